/* hdl/psfp_pkg.sv */
package psfp_pkg;

  localparam int unsigned FRAME_BYTES = 32;
  localparam int unsigned SUM_BYTES   = 30;
  localparam int unsigned WORD_COUNT  = 14;
  localparam int unsigned EMIT_COUNT  = 13;

  localparam int unsigned POS_W   = $clog2(FRAME_BYTES);
  localparam int unsigned WADDR_W = $clog2(WORD_COUNT);

  localparam logic [7:0] START_BYTE = 8'h42;
  localparam logic [POS_W-1:0] SUM_END  = POS_W'(SUM_BYTES);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);
  localparam logic [3:0] LAST_INDEX = 4'(EMIT_COUNT - 1);

  typedef enum logic [1:0] {
    ST_ACCEPT,
    ST_READ,
    ST_LOAD,
    ST_FAIL
  } psfp_state_t;

endpackage

/* hdl/psfp_if.sv */
interface psfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface psfp_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  word_index;
  logic [15:0] word_value;
  logic        frame_ok;
  logic        last;

  modport source (output valid, output word_index, output word_value, output frame_ok,
                  output last, input ready);
  modport sink (input valid, input word_index, input word_value, input frame_ok,
                input last, output ready);
endinterface

/* hdl/psfp_ram.sv */
module psfp_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 14
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hdl/particle_sensor_frame_parser.sv */
// Parses the 32-byte frames of a particle sensor's serial link. Bytes are taken one per
// cycle; outside a frame every byte but the start byte 0x42 is dropped. Frame words go
// into a small word store as they arrive, and the checksum is compared on the final byte.
// A good frame then yields 13 words (index 0 to 12, last on index 12), each fetched in
// a read state and then a load state, because every word goes through the store's single
// registered read port; a bad frame yields a single word with frame_ok low. No byte is
// taken while a run is being sent out.
module particle_sensor_frame_parser
  import psfp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  psfp_in_if.sink   in_ch,
  psfp_out_if.source out_ch
);

  psfp_state_t state, state_next;

  logic                 searching, searching_next;
  logic [POS_W-1:0]     byte_pos, byte_pos_next;
  logic [15:0]          running_sum, running_sum_next;
  logic [7:0]           held_high, held_high_next;
  logic [3:0]           rd_idx, rd_idx_next;

  logic                 out_valid;
  logic [3:0]           out_index;
  logic [15:0]          out_value;
  logic                 out_ok;
  logic                 out_last;

  logic                 take;
  logic                 out_free;
  logic                 ld_word;
  logic                 ld_fail;
  logic [15:0]          word;

  logic                 wr_en;
  logic [WADDR_W-1:0]   wr_addr;
  logic                 rd_en;
  logic [15:0]          rd_data;

  assign in_ch.ready = (state == ST_ACCEPT);
  assign take        = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid || out_ch.ready;
  assign word        = {held_high, in_ch.rx_byte};
  // Word k sits at frame bytes 2k+2 and 2k+3.
  assign wr_addr     = WADDR_W'(byte_pos[POS_W-1:1] - 4'd1);

  psfp_ram #(
    .WIDTH (16),
    .DEPTH (WORD_COUNT)
  ) u_words (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (word),
    .rd_en   (rd_en),
    .rd_addr (rd_idx[WADDR_W-1:0]),
    .rd_data (rd_data)
  );

  always_comb begin
    state_next       = state;
    searching_next   = searching;
    byte_pos_next    = byte_pos;
    running_sum_next = running_sum;
    held_high_next   = held_high;
    rd_idx_next      = rd_idx;
    wr_en            = 1'b0;
    rd_en            = 1'b0;
    ld_word          = 1'b0;
    ld_fail          = 1'b0;
    unique case (state)
      ST_ACCEPT: begin
        if (take) begin
          if (searching) begin
            if (in_ch.rx_byte == START_BYTE) begin
              searching_next   = 1'b0;
              running_sum_next = {8'd0, in_ch.rx_byte};
              byte_pos_next    = POS_W'(1);
            end
          end else begin
            byte_pos_next = byte_pos + POS_W'(1);
            if (byte_pos < SUM_END) begin
              running_sum_next = running_sum + {8'd0, in_ch.rx_byte};
            end
            if (!byte_pos[0]) begin
              held_high_next = in_ch.rx_byte;
            end else if (byte_pos == LAST_POS) begin
              searching_next = 1'b1;
              byte_pos_next  = '0;
              rd_idx_next    = '0;
              state_next     = (word == running_sum) ? ST_READ : ST_FAIL;
            end else if (byte_pos >= POS_W'(3)) begin
              wr_en = 1'b1;
            end
          end
        end
      end
      ST_READ: begin
        rd_en      = 1'b1;
        state_next = ST_LOAD;
      end
      ST_LOAD: begin
        if (out_free) begin
          ld_word     = 1'b1;
          rd_idx_next = rd_idx + 4'd1;
          state_next  = (rd_idx == LAST_INDEX) ? ST_ACCEPT : ST_READ;
        end
      end
      ST_FAIL: begin
        if (out_free) begin
          ld_fail    = 1'b1;
          state_next = ST_ACCEPT;
        end
      end
      default: state_next = ST_ACCEPT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_ACCEPT;
      searching   <= 1'b1;
      byte_pos    <= '0;
      running_sum <= '0;
      held_high   <= '0;
      rd_idx      <= '0;
    end else begin
      state       <= state_next;
      searching   <= searching_next;
      byte_pos    <= byte_pos_next;
      running_sum <= running_sum_next;
      held_high   <= held_high_next;
      rd_idx      <= rd_idx_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ld_word || ld_fail) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_word) begin
      out_index <= rd_idx;
      out_value <= rd_data;
      out_ok    <= 1'b1;
      out_last  <= (rd_idx == LAST_INDEX);
    end else if (ld_fail) begin
      out_index <= '0;
      out_value <= '0;
      out_ok    <= 1'b0;
      out_last  <= 1'b1;
    end
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.word_index = out_index;
  assign out_ch.word_value = out_value;
  assign out_ch.frame_ok   = out_ok;
  assign out_ch.last       = out_last;

endmodule

/* hdl/psfp_checker.sv */
module psfp_checker
  import psfp_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  word_index,
  input logic [15:0] word_value,
  input logic        frame_ok,
  input logic        last
);

  // A stalled word must hold its payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(word_index) && $stable(word_value)
      && $stable(frame_ok) && $stable(last))
    else $error("stalled result changed");

  // A failed frame gives a single zeroed word that closes the run.
  a_fail: assert property (@(posedge clk) disable iff (rst)
    out_valid && !frame_ok |-> last && word_index == 4'd0 && word_value == 16'd0)
    else $error("malformed failure result");

  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_ok |-> (last == (word_index == LAST_INDEX)) && word_index <= LAST_INDEX)
    else $error("last marker misplaced");

  // Words of a good run come in order, and no byte is taken before the last one is loaded.
  a_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && frame_ok && !last
      |-> !in_ready ##1 !(out_valid && word_index == 4'd0))
    else $error("run broken or input taken mid-run");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind particle_sensor_frame_parser psfp_checker u_psfp_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .word_index (out_ch.word_index),
  .word_value (out_ch.word_value),
  .frame_ok   (out_ch.frame_ok),
  .last       (out_ch.last)
);

/* tb/tb_particle_sensor_frame_parser.sv */
module tb_particle_sensor_frame_parser;
  import psfp_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [3:0]  idx;
    logic [15:0] val;
    logic        ok;
    logic        last;
  } sensor_word_t;

  typedef logic [15:0] frame_payload_t [WORD_COUNT];

  logic clk;
  logic rst;

  psfp_in_if  in_ch ();
  psfp_out_if out_ch ();

  particle_sensor_frame_parser dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Predictor state for the frame being collected.
  logic        hunting;
  logic [4:0]  byte_pos;
  logic [15:0] frame_sum;
  logic [7:0]  high_byte;
  logic [15:0] word_store [WORD_COUNT];

  sensor_word_t expected_words [$];

  int errors;
  int bytes_taken;
  int frame_bytes;
  int good_frames;
  int bad_frames;
  int words_checked;
  int quiet_cycles;
  int gap_odds;
  int stall_odds;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Works out what the parser should emit for one accepted byte.
  task automatic track_byte(input logic [7:0] b);
    logic [15:0] pair;
    sensor_word_t w;
    bytes_taken++;
    if (hunting) begin
      if (b == START_BYTE) begin
        hunting = 1'b0;
        frame_sum = 16'(b);
        byte_pos = 5'd1;
        frame_bytes++;
      end
      return;
    end
    frame_bytes++;
    if (byte_pos < SUM_END) frame_sum = frame_sum + 16'(b);
    if (!byte_pos[0]) begin
      high_byte = b;
    end else if (byte_pos >= 5'd3) begin
      pair = {high_byte, b};
      if (byte_pos < SUM_END) begin
        word_store[(int'(byte_pos) - 2) >> 1] = pair;
      end else begin
        hunting = 1'b1;
        byte_pos = 5'd0;
        if (pair == frame_sum) begin
          for (int k = 0; k < EMIT_COUNT; k++) begin
            w.idx = 4'(k);
            w.val = word_store[k];
            w.ok = 1'b1;
            w.last = (4'(k) == LAST_INDEX);
            expected_words.push_back(w);
          end
          good_frames++;
        end else begin
          w.idx = 4'd0;
          w.val = 16'd0;
          w.ok = 1'b0;
          w.last = 1'b1;
          expected_words.push_back(w);
          bad_frames++;
        end
        return;
      end
    end
    byte_pos = byte_pos + 5'd1;
  endtask

  // Offers one byte, with an occasional gap first, and waits for it to be taken.
  task automatic push_rx_byte(input logic [7:0] b);
    if (gap_odds != 0 && $urandom_range(0, gap_odds - 1) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    track_byte(b);
  endtask

  task automatic send_frame(input logic [7:0] hdr2, input frame_payload_t payload,
                            input logic [15:0] corrupt);
    logic [15:0] sum;
    sum = 16'(START_BYTE) + 16'(hdr2);
    push_rx_byte(START_BYTE);
    push_rx_byte(hdr2);
    for (int i = 0; i < WORD_COUNT; i++) begin
      sum = sum + 16'(payload[i][15:8]) + 16'(payload[i][7:0]);
      push_rx_byte(payload[i][15:8]);
      push_rx_byte(payload[i][7:0]);
    end
    sum = sum ^ corrupt;
    push_rx_byte(sum[15:8]);
    push_rx_byte(sum[7:0]);
  endtask

  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 4))
      0: return 16'($urandom_range(0, 999));
      1: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      2: return 16'h1 << $urandom_range(0, 15);
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic frame_payload_t random_payload();
    frame_payload_t p;
    for (int i = 0; i < WORD_COUNT; i++) p[i] = pick_word();
    return p;
  endfunction

  function automatic logic [15:0] pick_corruption();
    return $urandom_range(0, 1) ? (16'h1 << $urandom_range(0, 15))
                                : 16'($urandom_range(1, 65535));
  endfunction

  // Sink side: ready drops for bursts of stall cycles.
  initial begin : drive_ready
    int stall_left;
    stall_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (stall_odds != 0 && $urandom_range(0, stall_odds - 1) == 0) begin
        stall_left = $urandom_range(1, 18) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_results
    sensor_word_t want;
    if (!rst && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (expected_words.size() == 0) begin
        $error("unexpected word: index %0d value %h", out_ch.word_index, out_ch.word_value);
        errors++;
      end else begin
        want = expected_words.pop_front();
        words_checked++;
        if (out_ch.word_index !== want.idx) begin
          $error("word_index: expected %0d, got %0d", want.idx, out_ch.word_index);
          errors++;
        end
        if (out_ch.word_value !== want.val) begin
          $error("word_value: expected %h, got %h", want.val, out_ch.word_value);
          errors++;
        end
        if (out_ch.frame_ok !== want.ok) begin
          $error("frame_ok: expected %0b, got %0b", want.ok, out_ch.frame_ok);
          errors++;
        end
        if (out_ch.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, out_ch.last);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("status: fail");
    $finish;
  end

  task automatic test_hunting_noise();
    logic [7:0] noise [6] = '{8'h00, 8'hFF, 8'h41, 8'h43, 8'h4D, 8'hBD};
    foreach (noise[i]) push_rx_byte(noise[i]);
  endtask

  task automatic test_good_frame_extremes();
    frame_payload_t p;
    // Start bytes inside the data must be taken as plain frame data.
    p = '{16'h001C, 16'h0000, 16'hFFFF, 16'h4242, 16'h0042, 16'h8000, 16'h0001,
          16'hAAAA, 16'h5555, 16'h7FFF, 16'hFF00, 16'h00FF, 16'h1234, 16'hFFFF};
    send_frame(8'h4D, p, 16'h0000);
  endtask

  task automatic test_bad_checksums();
    frame_payload_t p;
    p = random_payload();
    send_frame(8'h00, p, 16'h0001);
    p = random_payload();
    send_frame(8'hFF, p, 16'h8000);
    // The second header byte is never checked, so an odd one still passes.
    p = random_payload();
    send_frame(START_BYTE, p, 16'h0000);
  endtask

  task automatic test_random_frames();
    int n;
    while (frame_bytes < 250) begin
      gap_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 12);
      stall_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 12);
      case ($urandom_range(0, 9))
        7: send_frame(8'($urandom_range(0, 255)), random_payload(), pick_corruption());
        8: begin
          n = $urandom_range(1, 5);
          repeat (n) push_rx_byte(8'($urandom_range(0, 255)));
        end
        9: begin
          // A frame cut short; the parser keeps counting into what follows.
          n = $urandom_range(1, 31);
          push_rx_byte(START_BYTE);
          repeat (n) push_rx_byte(8'($urandom_range(0, 255)));
        end
        default: send_frame($urandom_range(0, 3) == 0 ? 8'($urandom_range(0, 255)) : 8'h4D,
                            random_payload(), 16'h0000);
      endcase
    end
  endtask

  task automatic test_back_to_back();
    gap_odds = 0;
    stall_odds = 0;
    send_frame(8'h4D, random_payload(), 16'h0000);
    send_frame(8'h4D, random_payload(), pick_corruption());
    send_frame(8'h4D, random_payload(), 16'h0000);
  endtask

  initial begin
    errors = 0;
    bytes_taken = 0;
    frame_bytes = 0;
    good_frames = 0;
    bad_frames = 0;
    words_checked = 0;
    gap_odds = 6;
    stall_odds = 6;
    hunting = 1'b1;
    byte_pos = 5'd0;
    frame_sum = 16'd0;
    high_byte = 8'd0;
    in_ch.valid = 1'b0;
    in_ch.rx_byte = 8'd0;
    rst = 1'b1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_hunting_noise();
    test_good_frame_extremes();
    test_bad_checksums();
    test_random_frames();
    test_back_to_back();
    in_ch.valid <= 1'b0;

    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d bytes, %0d of them inside frames.", bytes_taken, frame_bytes);
    $display("Frames: %0d with a good checksum, %0d with a bad one; %0d words checked.",
             good_frames, bad_frames, words_checked);
    if (errors == 0 && expected_words.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
